>>> src/mac_forwarding_table_with_aging_macros.svh
// Assertion helpers used by the forwarding table controller.
`ifndef MAC_FORWARDING_TABLE_WITH_AGING_MACROS_SVH
`define MAC_FORWARDING_TABLE_WITH_AGING_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MFTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("forwarding table assertion failed");

// Next-cycle implication, disabled in reset.
`define MFTA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("forwarding table assertion failed");

`endif

>>> src/mfta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mfta_pkg;

  localparam int DEF_ENTRIES = 64;
  localparam logic [15:0] MAX_TTL_RESET = 16'd300;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_TICK   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [6:0] REMOVED_MAX = 7'd127;

  // command token walking down the cell row
  typedef struct packed {
    logic        valid;
    logic [1:0]  action;
    logic [47:0] mac;
    logic        is_ipv6;
    logic [15:0] port;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        found;
    logic        free_found;
    logic        f_is_ipv6;
    logic [15:0] f_port;
    logic [63:0] f_addr_high;
    logic [63:0] f_addr_low;
    logic [6:0]  removed;
  } tok_t;

  // slot load for an add that missed
  typedef struct packed {
    logic        en;
    logic [47:0] mac;
    logic        is_ipv6;
    logic [15:0] port;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } wr_t;

endpackage
`default_nettype wire

>>> src/mac_forwarding_table_with_aging.sv
// A command accepted on start is registered into the head token, which walks the
// row of ENTRIES slot cells one cell per cycle; the result is registered from the
// tail token. Only one command is in flight: start is not accepted while busy.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Reset (rst, synchronous): all slots invalid, max_ttl = 300, block idle.
`timescale 1ns / 1ps
`default_nettype none
module mac_forwarding_table_with_aging #(
  parameter int ENTRIES = mfta_pkg::DEF_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [47:0] mac,
  input  wire logic        vtep_is_ipv6,
  input  wire logic [15:0] vtep_port,
  input  wire logic [63:0] vtep_addr_high,
  input  wire logic [63:0] vtep_addr_low,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  output logic             done,
  output logic [1:0]       status,
  output logic             found_is_ipv6,
  output logic [15:0]      found_port,
  output logic [63:0]      found_addr_high,
  output logic [63:0]      found_addr_low,
  output logic [6:0]       removed_count
);
  import mfta_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  tok_t             chain [ENTRIES+1];
  logic [IDX_W-1:0] fidx  [ENTRIES+1];
  wr_t              wr;
  logic [15:0]      max_ttl;

  assign fidx[0] = '0;

  mfta_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .mac             (mac),
    .vtep_is_ipv6    (vtep_is_ipv6),
    .vtep_port       (vtep_port),
    .vtep_addr_high  (vtep_addr_high),
    .vtep_addr_low   (vtep_addr_low),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .max_ttl         (max_ttl),
    .head            (chain[0]),
    .tail            (chain[ENTRIES]),
    .wr              (wr),
    .done            (done),
    .status          (status),
    .found_is_ipv6   (found_is_ipv6),
    .found_port      (found_port),
    .found_addr_high (found_addr_high),
    .found_addr_low  (found_addr_low),
    .removed_count   (removed_count)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    mfta_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .tok_in       (chain[i]),
      .free_idx_in  (fidx[i]),
      .tok_out      (chain[i+1]),
      .free_idx_out (fidx[i+1]),
      .wr           (wr),
      .wr_idx       (fidx[ENTRIES]),
      .max_ttl      (max_ttl)
    );
  end

endmodule
`default_nettype wire

>>> src/mfta_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module mfta_cell #(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mfta_pkg::tok_t    tok_in,
  input  wire logic [IDX_W-1:0]  free_idx_in,
  output mfta_pkg::tok_t         tok_out,
  output logic [IDX_W-1:0]       free_idx_out,
  input  wire mfta_pkg::wr_t     wr,
  input  wire logic [IDX_W-1:0]  wr_idx,
  input  wire logic [15:0]       max_ttl
);
  import mfta_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic        valid;
  logic [47:0] mac;
  logic [15:0] ttl;
  logic        is_ipv6;
  logic [15:0] port;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  tok_t        tok;
  logic [IDX_W-1:0] free_idx;

  tok_t             tok_next;
  logic [IDX_W-1:0] free_idx_next;
  logic             valid_next;
  logic [15:0]      ttl_next;
  logic             hit;
  logic             load_tok;
  logic             load_wr;

  always_comb begin
    tok_next      = tok_in;
    free_idx_next = free_idx_in;
    valid_next    = valid;
    ttl_next      = ttl;
    load_tok      = 1'b0;
    load_wr       = wr.en && (wr_idx == MY_IDX);
    hit           = valid && (mac == tok_in.mac) && !tok_in.found;
    if (tok_in.valid) begin
      unique case (tok_in.action)
        ACT_LOOKUP: begin
          if (hit) begin
            tok_next.found       = 1'b1;
            tok_next.f_is_ipv6   = is_ipv6;
            tok_next.f_port      = port;
            tok_next.f_addr_high = addr_high;
            tok_next.f_addr_low  = addr_low;
          end
        end
        ACT_ADD: begin
          if (hit) begin
            tok_next.found = 1'b1;
            load_tok       = 1'b1;
          end
        end
        ACT_DELETE: begin
          if (hit) begin
            tok_next.found = 1'b1;
            valid_next     = 1'b0;
          end
        end
        ACT_TICK: begin
          if (valid) begin
            if (ttl <= 16'd1) begin
              valid_next = 1'b0;
              ttl_next   = 16'd0;
              if (tok_in.removed < REMOVED_MAX) begin
                tok_next.removed = tok_in.removed + 7'd1;
              end
            end else begin
              ttl_next = ttl - 16'd1;
            end
          end
        end
      endcase
      if (!valid && !tok_in.free_found) begin
        tok_next.free_found = 1'b1;
        free_idx_next       = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      tok.valid <= 1'b0;
    end else begin
      valid <= (load_tok || load_wr) ? 1'b1 : valid_next;
      tok   <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    free_idx <= free_idx_next;
    ttl      <= (load_tok || load_wr) ? max_ttl : ttl_next;
    if (load_tok) begin
      mac       <= tok_in.mac;
      is_ipv6   <= tok_in.is_ipv6;
      port      <= tok_in.port;
      addr_high <= tok_in.addr_high;
      addr_low  <= tok_in.addr_low;
    end else if (load_wr) begin
      mac       <= wr.mac;
      is_ipv6   <= wr.is_ipv6;
      port      <= wr.port;
      addr_high <= wr.addr_high;
      addr_low  <= wr.addr_low;
    end
  end

  assign tok_out      = tok;
  assign free_idx_out = free_idx;

endmodule
`default_nettype wire

>>> src/mfta_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mfta_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire logic [1:0]     action,
  input  wire logic [47:0]    mac,
  input  wire logic           vtep_is_ipv6,
  input  wire logic [15:0]    vtep_port,
  input  wire logic [63:0]    vtep_addr_high,
  input  wire logic [63:0]    vtep_addr_low,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [15:0]    cfg_data,
  output logic [15:0]         max_ttl,
  output mfta_pkg::tok_t      head,
  input  wire mfta_pkg::tok_t tail,
  output mfta_pkg::wr_t       wr,
  output logic                done,
  output logic [1:0]          status,
  output logic                found_is_ipv6,
  output logic [15:0]         found_port,
  output logic [63:0]         found_addr_high,
  output logic [63:0]         found_addr_low,
  output logic [6:0]          removed_count
);
  import mfta_pkg::*;
  `include "mac_forwarding_table_with_aging_macros.svh"

  logic       accept;
  logic [1:0] status_next;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    status_next = ST_OK;
    if (tail.valid) begin
      unique case (tail.action)
        ACT_LOOKUP: status_next = tail.found ? ST_OK : ST_NOT_FOUND;
        ACT_ADD:    status_next = (tail.found || tail.free_found) ? ST_OK : ST_FULL;
        ACT_DELETE: status_next = tail.found ? ST_OK : ST_NOT_FOUND;
        ACT_TICK:   status_next = ST_OK;
      endcase
    end
    wr.en        = tail.valid && (tail.action == ACT_ADD) && !tail.found
                   && tail.free_found;
    wr.mac       = tail.mac;
    wr.is_ipv6   = tail.is_ipv6;
    wr.port      = tail.port;
    wr.addr_high = tail.addr_high;
    wr.addr_low  = tail.addr_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      head.valid <= 1'b0;
      max_ttl    <= MAX_TTL_RESET;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (tail.valid) begin
        busy <= 1'b0;
      end
      done       <= tail.valid;
      head.valid <= accept;
      if (accept) begin
        head.action      <= action;
        head.mac         <= mac;
        head.is_ipv6     <= vtep_is_ipv6;
        head.port        <= vtep_port;
        head.addr_high   <= vtep_addr_high;
        head.addr_low    <= vtep_addr_low;
        head.found       <= 1'b0;
        head.free_found  <= 1'b0;
        head.f_is_ipv6   <= 1'b0;
        head.f_port      <= 16'd0;
        head.f_addr_high <= 64'd0;
        head.f_addr_low  <= 64'd0;
        head.removed     <= 7'd0;
      end
      if (cfg_valid && cfg_ready) begin
        max_ttl <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      status          <= status_next;
      found_is_ipv6   <= tail.f_is_ipv6;
      found_port      <= tail.f_port;
      found_addr_high <= tail.f_addr_high;
      found_addr_low  <= tail.f_addr_low;
      removed_count   <= tail.removed;
    end
  end

  `MFTA_ASSERT_NXT(a_accept_busy, accept, busy)
  `MFTA_ASSERT_IMP(a_done_idle, done, !busy)
  `MFTA_ASSERT_IMP(a_tail_in_flight, tail.valid, busy && !head.valid)
  `MFTA_ASSERT_IMP(a_miss_no_data, done && (status != ST_OK), removed_count == 7'd0)
  `MFTA_ASSERT_IMP(a_wr_only_tail, wr.en, tail.valid && !tail.found)

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import mfta_pkg::*;

  localparam int ENTRIES = DEF_ENTRIES;
  localparam int POOL = 80;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_ipv6;
    logic [15:0] port;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [6:0]  removed;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  action = ACT_LOOKUP;
  logic [47:0] mac = '0;
  logic        vtep_is_ipv6 = 1'b0;
  logic [15:0] vtep_port = '0;
  logic [63:0] vtep_addr_high = '0;
  logic [63:0] vtep_addr_low = '0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        busy, cfg_ready, done, found_is_ipv6;
  logic [1:0]  status;
  logic [15:0] found_port;
  logic [63:0] found_addr_high, found_addr_low;
  logic [6:0]  removed_count;

  mac_forwarding_table_with_aging #(.ENTRIES(ENTRIES)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .mac(mac), .vtep_is_ipv6(vtep_is_ipv6),
    .vtep_port(vtep_port), .vtep_addr_high(vtep_addr_high),
    .vtep_addr_low(vtep_addr_low),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status), .found_is_ipv6(found_is_ipv6),
    .found_port(found_port), .found_addr_high(found_addr_high),
    .found_addr_low(found_addr_low), .removed_count(removed_count)
  );

  always #5 clk = ~clk;

  // shadow copy of the forwarding table
  bit          slot_live [ENTRIES];
  logic [47:0] slot_key  [ENTRIES];
  logic [15:0] slot_life [ENTRIES];
  logic        slot_v6   [ENTRIES];
  logic [15:0] slot_udp  [ENTRIES];
  logic [63:0] slot_hi   [ENTRIES];
  logic [63:0] slot_lo   [ENTRIES];
  logic [15:0] ttl_setting = MAX_TTL_RESET;

  reply_t      awaited_replies[$];
  reply_t      next_reply;
  logic [47:0] mac_pool [POOL];
  int          err_count = 0;
  int          burst_left = 4;

  function automatic reply_t forward_table_apply(input logic [1:0] act,
      input logic [47:0] key, input logic v6, input logic [15:0] prt,
      input logic [63:0] hi, input logic [63:0] lo);
    reply_t r;
    int hit;
    int slot;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
    case (act)
      ACT_LOOKUP: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.is_ipv6 = slot_v6[hit];
          r.port = slot_udp[hit];
          r.addr_high = slot_hi[hit];
          r.addr_low = slot_lo[hit];
        end
      end
      ACT_ADD: begin
        slot = hit;
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !slot_live[i]) slot = i;
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_key[slot] = key;
          slot_v6[slot] = v6;
          slot_udp[slot] = prt;
          slot_hi[slot] = hi;
          slot_lo[slot] = lo;
          slot_life[slot] = ttl_setting;
          slot_live[slot] = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else slot_live[hit] = 1'b0;
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_live[i]) begin
            if (slot_life[i] <= 16'd1) begin
              slot_life[i] = '0;
              slot_live[i] = 1'b0;
              if (r.removed < REMOVED_MAX) r.removed = r.removed + 7'd1;
            end else begin
              slot_life[i] = slot_life[i] - 16'd1;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
      input logic [63:0] want);
    $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("result with no command pending", 64'(status), 64'd0);
      end else begin
        next_reply = awaited_replies.pop_front();
        if (status !== next_reply.status)
          report_mismatch("status", 64'(status), 64'(next_reply.status));
        if (found_is_ipv6 !== next_reply.is_ipv6)
          report_mismatch("found_is_ipv6", 64'(found_is_ipv6),
                          64'(next_reply.is_ipv6));
        if (found_port !== next_reply.port)
          report_mismatch("found_port", 64'(found_port), 64'(next_reply.port));
        if (found_addr_high !== next_reply.addr_high)
          report_mismatch("found_addr_high", found_addr_high, next_reply.addr_high);
        if (found_addr_low !== next_reply.addr_low)
          report_mismatch("found_addr_low", found_addr_low, next_reply.addr_low);
        if (removed_count !== next_reply.removed)
          report_mismatch("removed_count", 64'(removed_count),
                          64'(next_reply.removed));
      end
    end
  end

  // one command transfer; bursts of back-to-back commands with random gaps
  task automatic send_cmd(input logic [1:0] act, input logic [47:0] key,
      input logic v6, input logic [15:0] prt, input logic [63:0] hi,
      input logic [63:0] lo);
    int gap;
    start <= 1'b1;
    action <= act;
    mac <= key;
    vtep_is_ipv6 <= v6;
    vtep_port <= prt;
    vtep_addr_high <= hi;
    vtep_addr_low <= lo;
    do @(posedge clk); while (busy);
    awaited_replies.push_back(forward_table_apply(act, key, v6, prt, hi, lo));
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 16);
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_ttl(input logic [15:0] value);
    wait_idle();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ttl_setting = value;
  endtask

  task automatic send_random(input int add_pct, input int tick_pct);
    int pick;
    logic [1:0] act;
    logic [47:0] key;
    logic v6;
    logic [63:0] hi, lo;
    pick = $urandom_range(99);
    if (pick < add_pct) act = ACT_ADD;
    else if (pick < add_pct + tick_pct) act = ACT_TICK;
    else if ($urandom_range(2) == 0) act = ACT_DELETE;
    else act = ACT_LOOKUP;
    key = ($urandom_range(99) < 85) ? mac_pool[$urandom_range(POOL - 1)]
                                    : 48'(rand64());
    v6 = 1'($urandom_range(1));
    hi = v6 ? rand64() : 64'd0;
    lo = v6 ? rand64() : {32'd0, $urandom};
    send_cmd(act, key, v6, 16'($urandom_range(16'hFFFF)), hi, lo);
  endtask

  task automatic test_empty_table();
    send_cmd(ACT_LOOKUP, 48'h0123_4567_89AB, 1'b0, 16'd0, 64'd0, 64'd0);
    send_cmd(ACT_DELETE, 48'hFFFF_FFFF_FFFF, 1'b0, 16'd0, 64'd0, 64'd0);
    send_cmd(ACT_TICK, 48'hFFFF_FFFF_FFFF, 1'b1, 16'hFFFF, '1, '1);
  endtask

  task automatic test_add_lookup_delete();
    send_cmd(ACT_ADD, 48'h0, 1'b0, 16'd0, 64'd0, 64'd0);
    send_cmd(ACT_ADD, 48'hFFFF_FFFF_FFFF, 1'b1, 16'hFFFF, '1, '1);
    send_cmd(ACT_LOOKUP, 48'h0, 1'b1, 16'hFFFF, '1, '1);
    send_cmd(ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b0, 16'd0, 64'd0, 64'd0);
    send_cmd(ACT_DELETE, 48'h0, 1'b0, 16'd0, 64'd0, 64'd0);
    send_cmd(ACT_LOOKUP, 48'h0, 1'b0, 16'd0, 64'd0, 64'd0);
    send_cmd(ACT_DELETE, 48'h0, 1'b0, 16'd0, 64'd0, 64'd0);
  endtask

  task automatic test_refresh();
    send_cmd(ACT_ADD, 48'hFFFF_FFFF_FFFF, 1'b0, 16'd4789, 64'd0,
             64'h0000_0000_C0A8_0101);
    send_cmd(ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b0, 16'd0, 64'd0, 64'd0);
    send_cmd(ACT_TICK, 48'hA5A5_A5A5_A5A5, 1'b1, 16'h5A5A, rand64(), rand64());
  endtask

  task automatic test_ttl_expiry();
    write_max_ttl(16'd0);
    send_cmd(ACT_ADD, 48'h0000_0000_0001, 1'b1, 16'd1, rand64(), rand64());
    send_cmd(ACT_TICK, 48'h0, 1'b0, 16'd0, 64'd0, 64'd0);
    send_cmd(ACT_LOOKUP, 48'h0000_0000_0001, 1'b0, 16'd0, 64'd0, 64'd0);
    write_max_ttl(16'd1);
    send_cmd(ACT_ADD, 48'h0000_0000_0002, 1'b0, 16'd2, 64'd0, 64'd2);
    send_cmd(ACT_ADD, 48'h0000_0000_0003, 1'b0, 16'd3, 64'd0, 64'd3);
    send_cmd(ACT_TICK, 48'h0, 1'b0, 16'd0, 64'd0, 64'd0);
    write_max_ttl(16'd2);
    send_cmd(ACT_ADD, 48'h0000_0000_0004, 1'b1, 16'd4, 64'd4, 64'd4);
    send_cmd(ACT_TICK, 48'h0, 1'b0, 16'd0, 64'd0, 64'd0);
    send_cmd(ACT_LOOKUP, 48'h0000_0000_0004, 1'b0, 16'd0, 64'd0, 64'd0);
    send_cmd(ACT_TICK, 48'h0, 1'b0, 16'd0, 64'd0, 64'd0);
  endtask

  task automatic test_random_traffic(input logic [15:0] ttl, input int count,
      input int add_pct, input int tick_pct, input bit drain_midway);
    write_max_ttl(ttl);
    for (int n = 0; n < count; n++) begin
      if (drain_midway && n == count / 2) wait_idle();
      send_random(add_pct, tick_pct);
    end
  endtask

  initial begin
    for (int i = 0; i < POOL; i++) mac_pool[i] = 48'(rand64());
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_add_lookup_delete();
    test_refresh();
    test_ttl_expiry();
    test_random_traffic(16'hFFFF, 300, 70, 2, 1'b0);
    test_random_traffic(16'd1, 300, 45, 15, 1'b0);
    test_random_traffic(16'd0, 150, 45, 15, 1'b0);
    test_random_traffic(16'd3, 300, 40, 15, 1'b0);
    test_random_traffic(MAX_TTL_RESET, 300, 40, 10, 1'b1);
    test_random_traffic(16'($urandom_range(4, 12)), 300, 45, 15, 1'b0);
    test_random_traffic(16'd40, 300, 75, 5, 1'b0);
    wait_idle();
    repeat (ENTRIES + 4) @(posedge clk);
    if (err_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
